@@ src/gmt_pkg.sv @@
package gmt_pkg;

  localparam logic [15:0] GROUP_EMPTY   = 16'h0000;
  localparam logic [15:0] GROUP_ALL     = 16'hFFFF;
  localparam logic [7:0]  ENDPOINT_NONE = 8'hFF;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_REM_PAIR = 3'd1;
  localparam logic [2:0] OP_REM_EP   = 3'd2;
  localparam logic [2:0] OP_REM_GRP  = 3'd3;
  localparam logic [2:0] OP_REM_ALL  = 3'd4;
  localparam logic [2:0] OP_QUERY    = 3'd5;
  localparam logic [2:0] OP_NOP      = 3'd7;

  localparam logic [2:0] ST_SUCCESS   = 3'd0;
  localparam logic [2:0] ST_FAILURE   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [0:0] CFG_GROUP_MIN = 1'd0;
  localparam logic [0:0] CFG_GROUP_MAX = 1'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] grp_id;
    logic [7:0]  endpoint_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_member;
    logic [4:0] free_entries;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] grp_id;
    logic [7:0]  endpoint_id;
  } cmd_t;

  typedef struct packed {
    logic dup;
    logic hit;
    logic member;
    logic empty_found;
  } scan_flags_t;

endpackage

@@ src/gmt_cell.sv @@
module gmt_cell
  import gmt_pkg::*;
#(
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic              token_in,
  input  scan_flags_t       flags_in,
  input  logic [IDX_W-1:0]  eidx_in,
  input  logic [CNT_W-1:0]  cnt_in,
  output logic              token_out_r,
  output scan_flags_t       flags_out_r,
  output logic [IDX_W-1:0]  eidx_out_r,
  output logic [CNT_W-1:0]  cnt_out_r
);

  logic [15:0]       grp_r;
  logic [7:0]        ep_r;
  logic              occ;
  logic              geq;
  logic              epeq;
  logic              pair;
  logic              clr;
  logic              empty_after;
  scan_flags_t       flags_nxt;
  logic [IDX_W-1:0]  eidx_nxt;

  assign occ  = (grp_r != GROUP_EMPTY);
  assign geq  = (grp_r == cmd.grp_id);
  assign epeq = (ep_r == cmd.endpoint_id);
  assign pair = occ && geq && epeq;

  always_comb begin
    clr       = 1'b0;
    flags_nxt = flags_in;
    eidx_nxt  = eidx_in;
    case (cmd.op)
      OP_ADD: begin
        if (pair) flags_nxt.dup = 1'b1;
        if (!occ && !flags_in.empty_found) begin
          flags_nxt.empty_found = 1'b1;
          eidx_nxt              = IDX_W'(CELL_IDX);
        end
      end
      OP_REM_PAIR: begin
        if (pair && !flags_in.hit) begin
          clr           = 1'b1;
          flags_nxt.hit = 1'b1;
        end
      end
      OP_REM_EP: begin
        if (occ && epeq) begin
          clr           = 1'b1;
          flags_nxt.hit = 1'b1;
        end
      end
      OP_REM_GRP: begin
        if (occ && geq) begin
          clr           = 1'b1;
          flags_nxt.hit = 1'b1;
        end
      end
      OP_REM_ALL: begin
        clr           = 1'b1;
        flags_nxt.hit = 1'b1;
      end
      OP_QUERY: begin
        if (pair) flags_nxt.member = 1'b1;
      end
      default: begin
      end
    endcase
    empty_after = clr || !occ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= GROUP_EMPTY;
      ep_r        <= ENDPOINT_NONE;
      token_out_r <= 1'b0;
    end else begin
      token_out_r <= token_in;
      if (token_in && clr) begin
        grp_r <= GROUP_EMPTY;
        ep_r  <= ENDPOINT_NONE;
      end else if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
        grp_r <= cmd.grp_id;
        ep_r  <= cmd.endpoint_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_out_r <= flags_nxt;
    eidx_out_r  <= eidx_nxt;
    cnt_out_r   <= cnt_in + CNT_W'(empty_after);
  end

endmodule

@@ src/group_membership_table.sv @@
// Group membership table: TABLE_ENTRIES (group id, endpoint id) pairs.
// Input channel in_valid/in_stall/in_word carries one command word (mode,
// group id, endpoint id); output channel out_valid/out_stall/out_word gives
// one result word per command (status, membership, free entry count).
// cfg_we/cfg_index/cfg_data write group_min (index 0) and group_max (index 1)
// and must only be written while the table is idle; the block itself does not enforce it.
// Each entry lives in its own cell; a token carrying the scan flags walks the
// row of cells, one cell a cycle, so every command costs one pass of the row.
// A taken command passes start_r, the cell row and res_r, and its result is then loaded
// into out_word_r and shown on out_valid; in_stall drops in that same cycle, so the
// next command can be taken as that result appears. A new command is not taken until
// the previous one's result has left res_r for the output register.
// An add writes its chosen entry at the end of the pass.
// Reset empties every entry (group 0, endpoint 255), restores group_min to 1
// and group_max to 65527 and drops any pending result.
// While out_stall is high a finished result is held in the output register;
// one further command is still taken and scanned, and its result then waits
// with the input stalled until the held word has been delivered.
module group_membership_table
  import gmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [15:0]  group_min_r;
  logic [15:0]  group_max_r;
  cmd_t         cmd_r, cmd_nxt;
  logic [2:0]   pre_status_r, pre_status_nxt;
  logic         gall_r;
  logic         start_r;
  out_word_t    res_r, res_nxt;
  out_word_t    out_word_r;
  logic         out_valid_r;

  logic         accept;
  logic         in_range;
  logic         scan_end;
  logic         wr_en;
  logic         out_free;
  logic [31:0]  free32;

  logic              tok   [TABLE_ENTRIES+1];
  scan_flags_t       flags [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]  eidx  [TABLE_ENTRIES+1];
  logic [CNT_W-1:0]  cnt   [TABLE_ENTRIES+1];

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_range = (in_word.grp_id >= group_min_r) && (in_word.grp_id <= group_max_r);

  always_comb begin
    cmd_nxt.grp_id      = in_word.grp_id;
    cmd_nxt.endpoint_id = in_word.endpoint_id;
    cmd_nxt.op          = OP_NOP;
    pre_status_nxt      = ST_INVALID;
    unique case (in_word.mode) inside
      OP_ADD: begin
        pre_status_nxt = ST_FAILURE;
        if (in_word.grp_id != GROUP_ALL && in_word.grp_id != GROUP_EMPTY && in_range)
          cmd_nxt.op = OP_ADD;
      end
      OP_REM_PAIR, OP_REM_GRP: begin
        if (in_range) cmd_nxt.op = in_word.mode;
      end
      OP_REM_EP, OP_REM_ALL: begin
        cmd_nxt.op = in_word.mode;
      end
      OP_QUERY: begin
        pre_status_nxt = ST_SUCCESS;
        if (in_word.grp_id == GROUP_ALL || in_range) cmd_nxt.op = OP_QUERY;
      end
      default: begin
      end
    endcase
  end

  // cell row
  assign tok[0]   = start_r;
  assign flags[0] = '0;
  assign eidx[0]  = '0;
  assign cnt[0]   = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    gmt_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd_r),
      .wr_en       (wr_en),
      .wr_idx      (eidx[TABLE_ENTRIES]),
      .token_in    (tok[i]),
      .flags_in    (flags[i]),
      .eidx_in     (eidx[i]),
      .cnt_in      (cnt[i]),
      .token_out_r (tok[i+1]),
      .flags_out_r (flags[i+1]),
      .eidx_out_r  (eidx[i+1]),
      .cnt_out_r   (cnt[i+1])
    );
  end

  assign scan_end = (state_r == S_SCAN) && tok[TABLE_ENTRIES];
  assign wr_en    = scan_end && (cmd_r.op == OP_ADD) && !flags[TABLE_ENTRIES].dup &&
                    flags[TABLE_ENTRIES].empty_found;
  assign free32   = 32'(cnt[TABLE_ENTRIES]) - 32'(wr_en);

  always_comb begin
    res_nxt.free_entries = free32[4:0];
    res_nxt.is_member    = 1'b0;
    res_nxt.status       = ST_SUCCESS;
    unique case (cmd_r.op) inside
      OP_ADD: begin
        if (flags[TABLE_ENTRIES].dup)               res_nxt.status = ST_DUPLICATE;
        else if (!flags[TABLE_ENTRIES].empty_found) res_nxt.status = ST_NO_SPACE;
      end
      OP_REM_PAIR, OP_REM_EP, OP_REM_GRP, OP_REM_ALL: begin
        if (!flags[TABLE_ENTRIES].hit) res_nxt.status = ST_NOT_FOUND;
      end
      OP_QUERY: begin
        res_nxt.is_member = gall_r || flags[TABLE_ENTRIES].member;
      end
      default: begin
        res_nxt.status = pre_status_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (scan_end) state_nxt = S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      group_min_r <= 16'd1;
      group_max_r <= 16'd65527;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (state_r == S_HOLD && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)               out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GROUP_MIN: group_min_r <= cfg_data;
          CFG_GROUP_MAX: group_max_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= cmd_nxt;
      pre_status_r <= pre_status_nxt;
      gall_r       <= (in_word.grp_id == GROUP_ALL);
    end
    if (scan_end) res_r <= res_nxt;
    if (state_r == S_HOLD && out_free) out_word_r <= res_r;
  end

endmodule

@@ tb/membership_checker.sv @@
`timescale 1ns / 100ps
module membership_checker
  import gmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  logic [15:0] grp_lo;
  logic [15:0] grp_hi;
  logic [15:0] slot_group [TABLE_ENTRIES];
  logic [7:0]  slot_ep    [TABLE_ENTRIES];
  out_word_t   pending_results [$];
  out_word_t   want;
  int          errors = 0;

  function automatic bit group_ok(logic [15:0] g);
    return g >= grp_lo && g <= grp_hi;
  endfunction

  function automatic bit pair_present(logic [15:0] g, logic [7:0] ep);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_group[i] != GROUP_EMPTY && slot_group[i] == g && slot_ep[i] == ep)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic void empty_slot(int i);
    slot_group[i] = GROUP_EMPTY;
    slot_ep[i] = ENDPOINT_NONE;
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int free_n;
    bit done;
    r = '0;
    r.status = ST_SUCCESS;
    done = 1'b0;
    free_n = 0;
    case (w.mode)
      OP_ADD: begin
        if (w.grp_id == GROUP_ALL || w.grp_id == GROUP_EMPTY || !group_ok(w.grp_id))
          r.status = ST_FAILURE;
        else if (pair_present(w.grp_id, w.endpoint_id))
          r.status = ST_DUPLICATE;
        else begin
          r.status = ST_NO_SPACE;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!done && slot_group[i] == GROUP_EMPTY) begin
              slot_group[i] = w.grp_id;
              slot_ep[i] = w.endpoint_id;
              done = 1'b1;
              r.status = ST_SUCCESS;
            end
        end
      end
      OP_REM_PAIR: begin
        if (!group_ok(w.grp_id))
          r.status = ST_INVALID;
        else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!done && slot_group[i] != GROUP_EMPTY && slot_group[i] == w.grp_id &&
                slot_ep[i] == w.endpoint_id) begin
              empty_slot(i);
              done = 1'b1;
              r.status = ST_SUCCESS;
            end
        end
      end
      OP_REM_EP: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_group[i] != GROUP_EMPTY && slot_ep[i] == w.endpoint_id) begin
            empty_slot(i);
            r.status = ST_SUCCESS;
          end
      end
      OP_REM_GRP: begin
        if (!group_ok(w.grp_id))
          r.status = ST_INVALID;
        else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_group[i] != GROUP_EMPTY && slot_group[i] == w.grp_id) begin
              empty_slot(i);
              r.status = ST_SUCCESS;
            end
        end
      end
      OP_REM_ALL: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          empty_slot(i);
      end
      OP_QUERY: begin
        r.is_member = (w.grp_id == GROUP_ALL) ||
                      (group_ok(w.grp_id) && pair_present(w.grp_id, w.endpoint_id));
      end
      default: r.status = ST_INVALID;
    endcase
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_group[i] == GROUP_EMPTY)
        free_n++;
    r.free_entries = free_n[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      grp_lo = 16'd1;
      grp_hi = 16'd65527;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        empty_slot(i);
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result word: status %0d member %0d free %0d",
                     $time, out_word.status, out_word.is_member, out_word.free_entries);
        end else begin
          want = pending_results.pop_front();
          if (out_word.status !== want.status || out_word.is_member !== want.is_member ||
              out_word.free_entries !== want.free_entries) begin
            errors++;
            if (errors <= 10)
              $display({"[%0t] result mismatch: expected status %0d member %0d free %0d,",
                        " got status %0d member %0d free %0d"},
                       $time, want.status, want.is_member, want.free_entries,
                       out_word.status, out_word.is_member, out_word.free_entries);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(apply_command(in_word));
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUP_MIN: grp_lo = cfg_data;
          CFG_GROUP_MAX: grp_hi = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    outstanding <= pending_results.size();
  end

endmodule

@@ tb/tb_group_membership_table.sv @@
`timescale 1ns / 100ps
module tb_group_membership_table;
  import gmt_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF    = 300;
  localparam int DRAIN_TAIL  = 40;
  localparam int BLOCK_WORDS = 51;
  localparam logic [2:0] OP_SPARE = 3'd6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          outstanding;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          quiet = 0;
  logic [15:0] lo_now = 16'd1;
  logic [15:0] hi_now = 16'd65527;

  always #1 clk = ~clk;

  group_membership_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  membership_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("group_membership_table verification failed");
      $finish;
    end
  end

  task automatic put_word(logic [2:0] m, logic [15:0] g, logic [7:0] ep);
    in_word_t w;
    w.mode = m;
    w.grp_id = g;
    w.endpoint_id = ep;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_range(logic [15:0] lo, logic [15:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GROUP_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_GROUP_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    lo_now = lo;
    hi_now = hi;
  endtask

  // mostly a small pool near the range ends so pairs collide and hit
  function automatic logic [15:0] pick_group();
    int r;
    int span;
    r = $urandom_range(0, 99);
    span = (hi_now >= lo_now) ? int'(hi_now - lo_now) : -1;
    if (r < 65 && span >= 0)
      return lo_now + 16'($urandom_range(0, span < 5 ? span : 5));
    if (r < 72 && span >= 0)
      return hi_now - 16'($urandom_range(0, span < 2 ? span : 2));
    if (r < 80)
      return $urandom_range(0, 1) ? GROUP_EMPTY : GROUP_ALL;
    if (r < 88)
      return $urandom_range(0, 1) ? lo_now - 16'd1 : hi_now + 16'd1;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_endpoint();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 8'($urandom_range(0, 5));
    if (r < 82)
      return $urandom_range(0, 1) ? ENDPOINT_NONE : 8'hFE;
    return 8'($urandom);
  endfunction

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_ADD;
    if (r < 50) return OP_QUERY;
    if (r < 64) return OP_REM_PAIR;
    if (r < 74) return OP_REM_EP;
    if (r < 84) return OP_REM_GRP;
    if (r < 88) return OP_REM_ALL;
    if (r < 91) return OP_SPARE;
    if (r < 94) return OP_NOP;
    return 3'($urandom);
  endfunction

  task automatic run_block(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 25) begin
        burst = $urandom_range(4, 18);
        if (burst > n - sent)
          burst = n - sent;
        repeat (burst) put_word(OP_ADD, pick_group(), pick_endpoint());
        sent += burst;
      end else begin
        put_word(pick_mode(), pick_group(), pick_endpoint());
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] lo_list [10];
    logic [15:0] hi_list [10];
    lo_list = '{16'd0, 16'd100, 16'd0, 16'hFFFF, 16'd40000,
                16'hFFFF, 16'd1, 16'd0, 16'd1, 16'd0};
    hi_list = '{16'hFFFF, 16'd131, 16'd0, 16'hFFFF, 16'd40003,
                16'd0, 16'd65527, 16'd0, 16'd4, 16'hFFFF};
    lo_list[7] = 16'($urandom_range(0, 65000));
    hi_list[7] = lo_list[7] + 16'($urandom_range(0, 500));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset range 1..65527
    put_word(OP_ADD, 16'd1, 8'd0);
    put_word(OP_ADD, 16'd65527, ENDPOINT_NONE);
    put_word(OP_ADD, GROUP_EMPTY, 8'd5);
    put_word(OP_ADD, GROUP_ALL, 8'd5);
    put_word(OP_ADD, 16'd65528, 8'd5);
    put_word(OP_ADD, 16'd1, 8'd0);
    put_word(OP_QUERY, 16'd1, 8'd0);
    put_word(OP_QUERY, GROUP_ALL, 8'd7);
    put_word(OP_QUERY, 16'd1, 8'd1);
    put_word(OP_QUERY, GROUP_EMPTY, ENDPOINT_NONE);
    put_word(OP_REM_PAIR, 16'd1, 8'd0);
    put_word(OP_REM_PAIR, 16'd1, 8'd0);
    put_word(OP_REM_PAIR, GROUP_EMPTY, 8'd5);
    put_word(OP_REM_EP, GROUP_EMPTY, ENDPOINT_NONE);
    put_word(OP_REM_EP, GROUP_EMPTY, ENDPOINT_NONE);
    put_word(OP_ADD, 16'd2, 8'd3);
    put_word(OP_ADD, 16'd2, 8'd4);
    put_word(OP_REM_GRP, 16'd2, 8'd0);
    put_word(OP_REM_GRP, 16'd2, 8'd0);
    put_word(OP_REM_GRP, GROUP_ALL, 8'd0);
    put_word(OP_ADD, 16'd3, 8'd3);
    put_word(OP_REM_ALL, GROUP_EMPTY, ENDPOINT_NONE);
    put_word(OP_SPARE, 16'hFFFF, 8'hFF);
    put_word(OP_NOP, 16'h0000, 8'h00);

    for (int b = 0; b < 10; b++) begin
      settle();
      case (b % 5)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        3: begin send_idle_pct = 26; stall_pct = 26; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      set_range(lo_list[b], hi_list[b]);
      // overfill the table: last two adds find no space
      if (b == 0)
        for (int i = 0; i < 18; i++)
          put_word(OP_ADD, 16'(1000 + i), 8'(i));
      if (b == 3 || b == 8)
        hold_req = 1'b1;
      run_block(BLOCK_WORDS / 2);
      if (b == 1 || b == 6)
        settle();
      run_block(BLOCK_WORDS - BLOCK_WORDS / 2);
    end

    settle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("group_membership_table verification clean");
    else
      $display("group_membership_table verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/gmt_pkg.sv
src/gmt_cell.sv
src/group_membership_table.sv
tb/membership_checker.sv
tb/tb_group_membership_table.sv
